[rtl/core/pru_pkg.sv]
// ============================================================================
// pru_pkg: shared types and constants of the pixel replicating upscaler
// Holds the widths, codes and struct types used by the front, queue, back
// and top-level modules.
// ============================================================================
package pru_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = $clog2(MAX_WIDTH + 1);

    // Field and register widths.
    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int SCALE_W     = 7;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int SCALE_LIMIT = 100;
    localparam int ROW_ALIGN   = 4;
    localparam int PAD_W       = $clog2(ROW_ALIGN);

    // Configuration channel.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output user field: status, then image end flag.
    localparam int OUT_USER_W  = STATUS_W + 1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_IDLE   = 3'd0,
        STAT_PIXEL  = 3'd1,
        STAT_PAD    = 3'd2,
        STAT_ACCEPT = 3'd3,
        STAT_REFUSE = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        status_t status;
        logic    row_end;
        logic    image_end;
    } result_ctrl_t;

    typedef struct packed {
        result_ctrl_t             ctrl;
        logic [PIXEL_W-1:0]       pixel;
    } queue_entry_t;

endpackage

[rtl/core/pru_front.sv]
// ============================================================================
// pru_front: item classifier, scan state and line store
// Accepts push and tick transfers, updates the row scan counters in the
// accepting cycle, writes or reads the line store and hands a classified
// result to the queue in the cycle after.
// ============================================================================
module pru_front
    import pru_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel.
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,
    input  logic                   s_tuser,
    // Queue side.
    input  logic [QCNT_W-1:0]      q_count,
    output logic                   stage_valid,
    output queue_entry_t           stage_entry
);

    // Effective configuration, clamped when written.
    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    // Scan state.
    logic [CNT_W-1:0]    pushed_count_reg,  pushed_count_next;
    logic [COL_W-1:0]    emit_column_reg,   emit_column_next;
    logic [SCALE_W-1:0]  copy_count_reg,    copy_count_next;
    logic [SCALE_W-1:0]  row_repeat_reg,    row_repeat_next;
    logic [PAD_W-1:0]    pad_remaining_reg, pad_remaining_next;
    logic                in_pad_phase_reg,  in_pad_phase_next;
    logic [HEIGHT_W-1:0] row_number_reg,    row_number_next;

    // Stage toward the queue.
    logic                stage_valid_reg;
    result_ctrl_t        stage_ctrl_reg, stage_ctrl_next;
    logic [PIXEL_W-1:0]  rd_data_reg;

    // Line store.
    logic [PIXEL_W-1:0]  line_store_mem [MAX_WIDTH];

    logic                accept;
    logic                mem_wr_en;
    logic                mem_rd_en;
    logic                do_finish;
    logic [SCALE_W-1:0]  scale_raw;
    logic [WIDTH_W-1:0]  width_raw;
    logic [3:0]          pad_prod;
    logic [3:0]          pad_bytes3;
    logic [PAD_W-1:0]    pad_bytes;
    logic [PAD_W-1:0]    pad_dec;
    logic [SCALE_W:0]    copy_inc;
    logic [SCALE_W:0]    repeat_inc;
    logic [CNT_W-1:0]    column_inc;
    logic [HEIGHT_W:0]   row_inc;

    // A slot is free when the queue and the stage together leave room.
    // Nothing is taken while reset is held.
    assign s_tready = aresetn &&
                      (({1'b0, q_count} + {{QCNT_W{1'b0}}, stage_valid_reg})
                       < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    assign scale_raw = cfg_data[SCALE_W-1:0];
    assign width_raw = cfg_data[WIDTH_W-1:0];

    // Configuration registers hold the clamped values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCALE: begin
                    if (scale_raw == '0) begin
                        scale_reg <= SCALE_W'(1);
                    end else if (scale_raw > SCALE_W'(SCALE_LIMIT)) begin
                        scale_reg <= SCALE_W'(SCALE_LIMIT);
                    end else begin
                        scale_reg <= scale_raw;
                    end
                end
                CFG_WIDTH: begin
                    if (width_raw == '0) begin
                        width_reg <= WIDTH_W'(1);
                    end else if (width_raw > WIDTH_W'(MAX_WIDTH)) begin
                        width_reg <= WIDTH_W'(MAX_WIDTH);
                    end else begin
                        width_reg <= width_raw;
                    end
                end
                CFG_HEIGHT: begin
                    height_reg <= (cfg_data == '0) ? HEIGHT_W'(1) : cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Pad bytes per output row: the row is width * scale * 3 bytes, and only
    // its value modulo four matters.
    assign pad_prod   = {2'b00, width_reg[1:0]} * {2'b00, scale_reg[1:0]};
    assign pad_bytes3 = {2'b00, pad_prod[1:0]} * 4'd3;
    assign pad_bytes  = PAD_W'(0) - pad_bytes3[PAD_W-1:0];

    // Increments shared by the branches below.
    assign pad_dec    = (pad_remaining_reg != '0) ? (pad_remaining_reg - PAD_W'(1)) : '0;
    assign copy_inc   = {1'b0, copy_count_reg} + (SCALE_W + 1)'(1);
    assign repeat_inc = {1'b0, row_repeat_reg} + (SCALE_W + 1)'(1);
    assign column_inc = {1'b0, emit_column_reg} + CNT_W'(1);
    assign row_inc    = {1'b0, row_number_reg} + (HEIGHT_W + 1)'(1);

    // Classify the accepted item and work out the next scan state.
    always_comb begin
        pushed_count_next  = pushed_count_reg;
        emit_column_next   = emit_column_reg;
        copy_count_next    = copy_count_reg;
        row_repeat_next    = row_repeat_reg;
        pad_remaining_next = pad_remaining_reg;
        in_pad_phase_next  = in_pad_phase_reg;
        row_number_next    = row_number_reg;
        stage_ctrl_next    = '{status: STAT_IDLE, row_end: 1'b0, image_end: 1'b0};
        mem_wr_en          = 1'b0;
        mem_rd_en          = 1'b0;
        do_finish          = 1'b0;

        if (accept) begin
            if (op_t'(s_tuser) == OP_PUSH) begin
                if ((row_repeat_reg == '0) &&
                    (pushed_count_reg < CNT_W'(width_reg))) begin
                    mem_wr_en              = 1'b1;
                    pushed_count_next      = pushed_count_reg + CNT_W'(1);
                    stage_ctrl_next.status = STAT_ACCEPT;
                end else begin
                    stage_ctrl_next.status = STAT_REFUSE;
                end
            end else if (in_pad_phase_reg) begin
                stage_ctrl_next.status = STAT_PAD;
                pad_remaining_next     = pad_dec;
                if (pad_dec == '0) begin
                    do_finish = 1'b1;
                end
            end else if ((row_repeat_reg != '0) ||
                         ({1'b0, emit_column_reg} < pushed_count_reg)) begin
                stage_ctrl_next.status = STAT_PIXEL;
                mem_rd_en              = 1'b1;
                if (copy_inc >= {1'b0, scale_reg}) begin
                    copy_count_next  = '0;
                    emit_column_next = column_inc[COL_W-1:0];
                    if (column_inc >= CNT_W'(width_reg)) begin
                        if (pad_bytes == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            in_pad_phase_next  = 1'b1;
                            pad_remaining_next = pad_bytes;
                        end
                    end
                end else begin
                    copy_count_next = copy_inc[SCALE_W-1:0];
                end
            end

            // End of an output row: rewind the scan, maybe advance the row.
            if (do_finish) begin
                stage_ctrl_next.row_end = 1'b1;
                emit_column_next        = '0;
                copy_count_next         = '0;
                in_pad_phase_next       = 1'b0;
                pad_remaining_next      = '0;
                if (repeat_inc >= {1'b0, scale_reg}) begin
                    row_repeat_next   = '0;
                    pushed_count_next = '0;
                    if (row_inc >= {1'b0, height_reg}) begin
                        row_number_next           = '0;
                        stage_ctrl_next.image_end = 1'b1;
                    end else begin
                        row_number_next = row_inc[HEIGHT_W-1:0];
                    end
                end else begin
                    row_repeat_next = repeat_inc[SCALE_W-1:0];
                end
            end
        end
    end

    // Scan state and stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pushed_count_reg  <= '0;
            emit_column_reg   <= '0;
            copy_count_reg    <= '0;
            row_repeat_reg    <= '0;
            pad_remaining_reg <= '0;
            in_pad_phase_reg  <= 1'b0;
            row_number_reg    <= '0;
            stage_valid_reg   <= 1'b0;
        end else begin
            pushed_count_reg  <= pushed_count_next;
            emit_column_reg   <= emit_column_next;
            copy_count_reg    <= copy_count_next;
            row_repeat_reg    <= row_repeat_next;
            pad_remaining_reg <= pad_remaining_next;
            in_pad_phase_reg  <= in_pad_phase_next;
            row_number_reg    <= row_number_next;
            stage_valid_reg   <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        stage_ctrl_reg <= stage_ctrl_next;
    end

    // Line store: one write port for pushes, one registered read for ticks.
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            line_store_mem[pushed_count_reg[COL_W-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= line_store_mem[emit_column_reg];
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage_entry = '{ctrl: stage_ctrl_reg, pixel: rd_data_reg};

endmodule

[rtl/core/pru_queue.sv]
// ============================================================================
// pru_queue: short result queue between front and back
// A small register FIFO; the front only writes when its credit check has
// reserved a slot, so no full flag is needed on the write side.
// ============================================================================
module pru_queue
    import pru_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  queue_entry_t      push_entry,
    input  logic              pop,
    output logic              head_valid,
    output queue_entry_t      head_entry,
    output logic [QCNT_W-1:0] count
);

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? (wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

[rtl/core/pru_back.sv]
// ============================================================================
// pru_back: result formatter and output register
// Takes one queued result per transfer, clears the colour bytes of every
// result that is not a pixel and holds it on the master side until taken.
// ============================================================================
module pru_back
    import pru_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  queue_entry_t          head_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,
    output logic                  m_tlast,
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic                  out_valid_reg;
    logic [PIXEL_W-1:0]    out_data_reg,  out_data_next;
    logic                  out_last_reg;
    logic [OUT_USER_W-1:0] out_user_reg,  out_user_next;

    // Load a new result whenever the output register is empty or draining.
    assign pop = head_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_data_next = (head_entry.ctrl.status == STAT_PIXEL) ? head_entry.pixel : '0;
        out_user_next = {head_entry.ctrl.image_end, head_entry.ctrl.status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= out_data_next;
            out_last_reg <= head_entry.ctrl.row_end;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

[rtl/core/pixel_replicating_upscaler_core.sv]
// ============================================================================
// pixel_replicating_upscaler_core: integer nearest-neighbor upscaler
// Replicates pushed 24-bit pixels and rows by the scale factor and pads
// every output row to a multiple of four bytes.
// ============================================================================
// Usage:
//   The slave stream carries push transfers (tuser 0, pixel in tdata) and
//   tick transfers (tuser 1). Every input transfer yields exactly one result
//   on the master stream: push accepted or refused, a pixel, a pad byte, or
//   idle when the needed pixel has not been pushed yet. tlast marks the end
//   of an output row and tuser bit 3 the end of the scaled image.
//   The configuration channel writes scale factor (index 0), source width
//   (index 1) and source height (index 2); it is ready whenever reset is
//   released and must only be used while no results are pending.
//   Throughput is one input transfer per cycle while s_tready is high: the
//   scan counters update in the accepting cycle and the line store is read
//   with one registered port. From an input transfer to its result, the item
//   passes the line store read stage, the queue and the output register.
//   A four-entry queue plus the output register absorb a stalled receiver;
//   s_tready drops once the queue and the read stage have no free slot.
//   Reset returns the registers to 1, clears all counters and starts a new
//   image; line store contents stay unknown until pushed.
// ============================================================================
module pixel_replicating_upscaler_core
    import pru_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,    // blue[7:0], green[15:8], red[23:16]
    input  logic                   s_tuser,    // op[0]
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PIXEL_W-1:0]     m_tdata,    // out_blue[7:0], out_green[15:8], out_red[23:16]
    output logic                   m_tlast,    // row_end
    output logic [OUT_USER_W-1:0]  m_tuser     // status[2:0], image_end[3]
);

    logic              stage_valid;
    queue_entry_t      stage_entry;
    logic              q_pop;
    logic              q_head_valid;
    queue_entry_t      q_head_entry;
    logic [QCNT_W-1:0] q_count;

    // Register writes are taken only outside reset.
    assign cfg_ready = aresetn;

    // Front: classification, scan state and line store.
    pru_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_count     (q_count),
        .stage_valid (stage_valid),
        .stage_entry (stage_entry)
    );

    // Queue between front and back.
    pru_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (stage_valid),
        .push_entry (stage_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .count      (q_count)
    );

    // Back: formatting and output register.
    pru_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // The queue plus the read stage never hold more than the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (({1'b0, q_count} + {{QCNT_W{1'b0}}, stage_valid})
         <= (QCNT_W + 1)'(QUEUE_DEPTH)))
        else $error("result queue overflow");

    // Every accepted input transfer enters the read stage in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> stage_valid)
        else $error("accepted transfer lost before the queue");

    // Results other than pixels carry zero colour bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_t'(m_tuser[STATUS_W-1:0]) != STAT_PIXEL))
        |-> (m_tdata == '0))
        else $error("non-pixel result with colour data");

    // The end of the image is always the end of a row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[OUT_USER_W-1]) |-> m_tlast)
        else $error("image end without row end");

endmodule

[test/pixel_replicating_upscaler_core_test.sv]
// ============================================================================
// pixel_replicating_upscaler_core_test: self-checking bench for the upscaler
// Sends push and tick transfers, predicts every result from its own model of
// the line store and scan counters, and compares each result transfer with
// the oldest prediction. Covers register extremes, refused pushes, idle
// ticks, pad bytes, row and image completion, and random pacing on both sides.
// ============================================================================
module pixel_replicating_upscaler_core_test;
    import pru_pkg::*;

    // Index that selects no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS  = 1500;
    localparam int MIN_PHASES   = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int LIMIT_CYCLES = 2000000;

    // Raw register contents as written.
    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } reg_file_t;

    // Register values as the scan logic uses them.
    typedef struct packed {
        int scale;
        int width;
        int height;
    } geometry_t;

    // Scan position within the scaled image.
    typedef struct packed {
        int pushed;
        int col;
        int copies;
        int repeats;
        int pad_left;
        int in_pad;
        int row;
    } scan_t;

    typedef struct packed {
        op_t                op;
        logic [PIXEL_W-1:0] px;
    } feed_item_t;

    typedef struct packed {
        status_t            status;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic               row_end;
        logic               image_end;
    } scaled_out_t;

    localparam reg_file_t REGS_AT_RESET = '{7'd1, 11'd1, 16'd1};

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [PIXEL_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic [OUT_USER_W-1:0]  m_tuser;

    pixel_replicating_upscaler_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Items waiting to be sent and results predicted for accepted items.
    feed_item_t  feed_q[$];
    scaled_out_t predicted_results[$];

    // Checking side: registers, scan state and line store of the block.
    reg_file_t          live_regs = REGS_AT_RESET;
    scan_t              live_scan = '0;
    logic [PIXEL_W-1:0] line_copy [MAX_WIDTH];

    // Planning side: the same model, advanced as items are queued.
    reg_file_t   plan_regs = REGS_AT_RESET;
    scan_t       plan_scan = '0;
    scaled_out_t last_plan;
    int          planned_items = 0;

    int errors        = 0;
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    bit s_taken       = 1'b0;

    function automatic void apply_reg(inout reg_file_t r, input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_SCALE:  r.scale  = d[SCALE_W-1:0];
            CFG_WIDTH:  r.width  = d[WIDTH_W-1:0];
            CFG_HEIGHT: r.height = d[HEIGHT_W-1:0];
            default: ;
        endcase
    endfunction

    // Out-of-range register values are clamped into the legal range.
    function automatic geometry_t clip_regs(reg_file_t r);
        geometry_t g;
        g.scale  = (r.scale == 0) ? 1 : (r.scale > SCALE_LIMIT) ? SCALE_LIMIT : int'(r.scale);
        g.width  = (r.width == 0) ? 1 : (r.width > MAX_WIDTH) ? MAX_WIDTH : int'(r.width);
        g.height = (r.height == 0) ? 1 : int'(r.height);
        return g;
    endfunction

    // Close one output row; returns 1 when it was the last row of the image.
    function automatic logic close_row(inout scan_t st, input geometry_t g);
        logic last;
        last        = 1'b0;
        st.col      = 0;
        st.copies   = 0;
        st.in_pad   = 0;
        st.pad_left = 0;
        st.repeats  = st.repeats + 1;
        if (st.repeats >= g.scale) begin
            st.repeats = 0;
            st.pushed  = 0;
            st.row     = st.row + 1;
            if (st.row >= g.height) begin
                st.row = 0;
                last   = 1'b1;
            end
        end
        return last;
    endfunction

    // One input item: advances the scan state and returns its result.
    // stored is the line store entry at the current column; store_wr asks
    // the caller to write the pushed pixel at the old push count.
    function automatic scaled_out_t upscale_step(inout scan_t st, input geometry_t g,
                                                 input feed_item_t it,
                                                 input logic [PIXEL_W-1:0] stored,
                                                 output logic store_wr);
        scaled_out_t r;
        int pad;
        r        = '0;
        r.status = STAT_IDLE;
        store_wr = 1'b0;
        if (it.op == OP_PUSH) begin
            if (st.repeats == 0 && st.pushed < g.width) begin
                store_wr  = 1'b1;
                st.pushed = st.pushed + 1;
                r.status  = STAT_ACCEPT;
            end else begin
                r.status = STAT_REFUSE;
            end
        end else if (st.in_pad != 0) begin
            r.status = STAT_PAD;
            if (st.pad_left > 0) st.pad_left = st.pad_left - 1;
            if (st.pad_left == 0) begin
                r.row_end   = 1'b1;
                r.image_end = close_row(st, g);
            end
        end else if (st.repeats != 0 || st.col < st.pushed) begin
            r.status  = STAT_PIXEL;
            r.blue    = stored[CHAN_W-1:0];
            r.green   = stored[2*CHAN_W-1:CHAN_W];
            r.red     = stored[3*CHAN_W-1:2*CHAN_W];
            st.copies = st.copies + 1;
            if (st.copies >= g.scale) begin
                st.copies = 0;
                st.col    = st.col + 1;
                if (st.col >= g.width) begin
                    pad = (ROW_ALIGN - (g.width * g.scale * 3) % ROW_ALIGN) % ROW_ALIGN;
                    if (pad == 0) begin
                        r.row_end   = 1'b1;
                        r.image_end = close_row(st, g);
                    end else begin
                        st.in_pad   = 1;
                        st.pad_left = pad;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [PIXEL_W-1:0] want, logic [PIXEL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Monitor and predictor: both transfer types are sampled at the rising edge.
    feed_item_t         acc_item;
    scaled_out_t        acc_res;
    scaled_out_t        want_res;
    logic [PIXEL_W-1:0] acc_rd;
    int                 acc_slot;
    logic               acc_wr;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual tdata %0h tuser %0h",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want_res = predicted_results.pop_front();
                    check_field("status", want_res.status, m_tuser[STATUS_W-1:0]);
                    check_field("image_end", want_res.image_end, m_tuser[STATUS_W]);
                    check_field("row_end", want_res.row_end, m_tlast);
                    check_field("out_blue", want_res.blue, m_tdata[CHAN_W-1:0]);
                    check_field("out_green", want_res.green, m_tdata[2*CHAN_W-1:CHAN_W]);
                    check_field("out_red", want_res.red, m_tdata[3*CHAN_W-1:2*CHAN_W]);
                end
            end
            if (cfg_valid && cfg_ready) apply_reg(live_regs, cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                acc_item.op = op_t'(s_tuser);
                acc_item.px = s_tdata;
                acc_slot    = live_scan.pushed;
                acc_rd      = (live_scan.col < MAX_WIDTH) ? line_copy[live_scan.col] : '0;
                acc_res     = upscale_step(live_scan, clip_regs(live_regs), acc_item, acc_rd, acc_wr);
                if (acc_wr) line_copy[acc_slot] = acc_item.px;
                predicted_results.push_back(acc_res);
                void'(feed_q.pop_front());
                s_taken = 1'b1;
            end
        end
    end

    // Driver: presents the next queued item at the falling edge, with random gaps.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (feed_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_tvalid <= 1'b1;
                s_tuser  <= feed_q[0].op;
                s_tdata  <= feed_q[0].px;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        s_taken = 1'b0;
    end

    task automatic set_pace(int mode);
        case (mode)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 78; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 78; end
            default: begin send_gap_pct = 22; stall_pct = 22; end
        endcase
    endtask

    // Queue one item and advance the planning model with it.
    task automatic send_item(op_t op, logic [PIXEL_W-1:0] px);
        feed_item_t it;
        logic       wr;
        it.op     = op;
        it.px     = px;
        last_plan = upscale_step(plan_scan, clip_regs(plan_regs), it, '0, wr);
        feed_q.push_back(it);
        planned_items++;
    endtask

    // Hold new items back until every predicted result has arrived.
    task automatic drain();
        while (feed_q.size() != 0 || predicted_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(plan_regs, idx, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_geometry(logic [CFG_DATA_W-1:0] scale, logic [CFG_DATA_W-1:0] width,
                                  logic [CFG_DATA_W-1:0] height);
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_HEIGHT, height);
    endtask

    // Run the current source row to the end of its last copy. Pushes and
    // ticks that advance the scan are mixed at random; with noise_pct,
    // refused pushes and idle ticks are thrown in where they change nothing.
    task automatic stream_row(int noise_pct);
        geometry_t g;
        bit        done;
        bit        can_push;
        bit        can_tick;
        op_t       op;
        done = 1'b0;
        while (!done) begin
            g        = clip_regs(plan_regs);
            can_push = (plan_scan.repeats == 0 && plan_scan.pushed < g.width);
            can_tick = (plan_scan.in_pad != 0 || plan_scan.repeats != 0 ||
                        plan_scan.col < plan_scan.pushed);
            if (can_push && can_tick)
                op = $urandom_range(1) ? OP_PUSH : OP_TICK;
            else if ($urandom_range(99) < noise_pct)
                op = can_push ? OP_TICK : OP_PUSH;
            else
                op = can_push ? OP_PUSH : OP_TICK;
            send_item(op, PIXEL_W'($urandom));
            done = (op == OP_TICK && last_plan.row_end && plan_scan.repeats == 0);
        end
    endtask

    // Stimulus: directed cases, register extremes, then random phases.
    initial begin
        int phase;
        int rows;
        int scale;
        int width;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: idle tick, pixel, refused push when full, pad byte.
        set_pace(0);
        send_item(OP_TICK, 24'hFFFFFF);
        send_item(OP_PUSH, 24'h000000);
        send_item(OP_TICK, 24'h000000);
        send_item(OP_PUSH, 24'hFFFFFF);
        send_item(OP_TICK, 24'h000000);
        drain();

        // Zero register values act as one; an unused index is ignored.
        write_geometry(16'd0, 16'd0, 16'd0);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_item(OP_PUSH, 24'hFFFFFF);
        send_item(OP_TICK, 24'hFFFFFF);
        send_item(OP_TICK, 24'h000000);
        drain();

        // Two copies of a one-pixel row: replays, pad bytes, refused pushes.
        write_reg(CFG_SCALE, 16'd2);
        send_item(OP_PUSH, 24'h5AA53C);
        send_item(OP_TICK, 24'h000000);
        send_item(OP_PUSH, 24'hC35AA5);
        stream_row(40);
        drain();

        // Scale above the limit, then lowered below the copies done mid-row.
        set_pace(3);
        write_geometry(16'hFFFF, 16'd1, 16'd2);
        send_item(OP_PUSH, PIXEL_W'($urandom));
        repeat (150) send_item(OP_TICK, PIXEL_W'($urandom));
        drain();
        write_reg(CFG_SCALE, 16'd100);
        repeat (30) send_item(OP_TICK, PIXEL_W'($urandom));
        drain();
        write_reg(CFG_SCALE, 16'd1);
        stream_row(10);
        stream_row(10);
        drain();

        // Widest row, written exactly and then above the limit: the store
        // fills up, one more push is refused, and a narrower width then
        // ends the row after a few pixels.
        set_pace(0);
        write_geometry(16'd1, CFG_DATA_W'(MAX_WIDTH), 16'd1);
        repeat (MAX_WIDTH / 2) send_item(OP_PUSH, PIXEL_W'($urandom));
        drain();
        write_reg(CFG_WIDTH, 16'hFFFF);
        repeat (MAX_WIDTH / 2) send_item(OP_PUSH, PIXEL_W'($urandom));
        send_item(OP_PUSH, PIXEL_W'($urandom));
        repeat (8) send_item(OP_TICK, PIXEL_W'($urandom));
        drain();
        write_reg(CFG_WIDTH, 16'd2);
        stream_row(5);
        drain();

        // The tallest image.
        write_geometry(16'd3, 16'd3, 16'hFFFF);
        repeat (3) stream_row(10);
        drain();
        // Height now below the current row: the image ends after this row.
        write_reg(CFG_HEIGHT, 16'd2);
        stream_row(10);
        stream_row(10);

        // Random phases, each starting on a row boundary with all results in.
        phase = 0;
        while (phase < MIN_PHASES || planned_items < TOTAL_ITEMS) begin
            drain();
            set_pace(phase % 4);
            if ($urandom_range(9) == 0) begin
                scale = $urandom_range(2);
                width = $urandom_range(9, 40);
            end else begin
                scale = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(4);
                width = $urandom_range(8);
            end
            write_geometry(CFG_DATA_W'(scale), CFG_DATA_W'(width),
                           CFG_DATA_W'($urandom_range(4)));
            rows = $urandom_range(1, 4);
            repeat (rows) begin
                if ($urandom_range(99) < 20) begin
                    repeat ($urandom_range(3, 12))
                        send_item(op_t'($urandom_range(1)), PIXEL_W'($urandom));
                end
                stream_row(10);
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a stalled handshake.
    initial begin
        #(LIMIT_CYCLES * 8);
        $display("status: fail");
        $finish;
    end

endmodule

[pixel_replicating_upscaler_core.f]
rtl/core/pru_pkg.sv
rtl/core/pru_front.sv
rtl/core/pru_queue.sv
rtl/core/pru_back.sv
rtl/core/pixel_replicating_upscaler_core.sv
test/pixel_replicating_upscaler_core_test.sv
